### hw/rtl/cfps_pkg.sv
`timescale 1ns / 1ps

package cfps_pkg;

    localparam int OFFSET_BITS = 32;

    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 16;
    localparam int FIELD_W  = 16;
    localparam int OFFSET_W = 32;
    localparam int KIND_W   = 2;
    localparam int RESULT_W = INDEX_W + OFFSET_W + BYTE_W + OFFSET_W + 3 * FIELD_W;
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    localparam logic [31:0] MAGIC_WORD = 32'hCAFE_BABE;

    localparam logic [BYTE_W-1:0] TAG_UTF8        = 8'd1;
    localparam logic [BYTE_W-1:0] TAG_LONG        = 8'd5;
    localparam logic [BYTE_W-1:0] TAG_DOUBLE      = 8'd6;
    localparam logic [BYTE_W-1:0] TAG_CLASS       = 8'd7;
    localparam logic [BYTE_W-1:0] TAG_STRING      = 8'd8;
    localparam logic [BYTE_W-1:0] TAG_METHOD_HDL  = 8'd15;
    localparam logic [BYTE_W-1:0] TAG_METHOD_TYPE = 8'd16;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENTRY     = 2'd0,
        KIND_SUMMARY   = 2'd1,
        KIND_BAD_MAGIC = 2'd2
    } t_kind;

    // lowest field last, so it lands in the lowest bits
    typedef struct packed {
        logic [FIELD_W-1:0]  interface_count;
        logic [FIELD_W-1:0]  parent_index;
        logic [FIELD_W-1:0]  self_index;
        logic [OFFSET_W-1:0] pool_size;
        logic [BYTE_W-1:0]   entry_tag;
        logic [OFFSET_W-1:0] entry_offset;
        logic [INDEX_W-1:0]  entry_index;
    } t_payload;

    typedef struct packed {
        t_kind    kind;
        t_payload data;
    } t_result;

    // body length in bytes that follows a tag byte
    function automatic logic [3:0] body_size(input logic [BYTE_W-1:0] tag);
        logic [3:0] size;
        if (tag == TAG_UTF8 || tag == TAG_CLASS || tag == TAG_STRING
                || tag == TAG_METHOD_TYPE) begin
            size = 4'd2;
        end else if (tag == TAG_METHOD_HDL) begin
            size = 4'd3;
        end else if (tag == TAG_LONG || tag == TAG_DOUBLE) begin
            size = 4'd8;
        end else begin
            size = 4'd4;
        end
        return size;
    endfunction

endpackage

### hw/rtl/class_file_pool_scanner.sv
`timescale 1ns / 1ps
// class file constant pool scanner
// input stream: one class file byte per beat on s_axis_tdata; s_axis_tuser
//   high marks the first byte of a new file and restarts the parse
// output stream: at most one record per input beat, m_axis_tuser is the kind
//   (pool entry, class summary, bad magic), m_axis_tdata the record fields
// a pool entry record leaves on its tag byte, the summary on the last byte
//   of the interface count, the bad magic error on the fourth byte
// each record is registered in the output register, or in the skid register
// throughput: one byte per cycle while the skid register is empty; each byte
//   updates the parse counters and the pool offset adder
// stall: an output register plus one skid register; input stays ready while
//   the skid register is empty, so one record can wait at the output without
//   stopping the input
// reset: synchronous, active low; clears the parser to waiting for magic and
//   empties both output registers; no beat is presented during reset
// bytes after a summary or a bad magic are dropped until the next first byte
module class_file_pool_scanner (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [cfps_pkg::BYTE_W-1:0] s_axis_tdata,  // data_byte
    input  logic                        s_axis_tuser,  // first_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // entry_index, entry_offset, entry_tag, pool_size, self_index,
    // parent_index, interface_count
    output logic [cfps_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [cfps_pkg::KIND_W-1:0]  m_axis_tuser   // kind
);
    import cfps_pkg::*;

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_VERSION = 3'd1,
        PH_COUNT   = 3'd2,
        PH_TAG     = 3'd3,
        PH_BODY    = 3'd4,
        PH_ACCESS  = 3'd5,
        PH_DONE    = 3'd6
    } t_phase;

    t_phase                 r_phase, n_phase, w_phase;
    logic [2:0]             r_cnt, n_cnt, w_cnt;
    logic [23:0]            r_shift, n_shift, w_shift;
    logic [FIELD_W-1:0]     r_pool_count, n_pool_count;
    logic [INDEX_W:0]       r_index, n_index;
    logic [FIELD_W-1:0]     r_rem, n_rem, w_rem;
    logic [OFFSET_BITS-1:0] r_offset, n_offset;
    logic                   r_pending, n_pending;
    logic [FIELD_W-1:0]     r_this, n_this;
    logic [FIELD_W-1:0]     r_super, n_super;

    logic                   r_out_valid, r_skid_valid;
    t_result                r_out, r_skid;

    logic                   w_accept, w_pop, w_push, w_body_done;
    logic [BYTE_W-1:0]      w_byte;
    logic [FIELD_W-1:0]     w_word;
    logic [3:0]             w_size, w_n;
    t_result                w_res;

    assign s_axis_tready = !r_skid_valid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_pop         = r_out_valid && m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = TDATA_W'(r_out.data);

    always_comb begin
        w_phase = r_phase;
        w_cnt   = r_cnt;
        w_shift = r_shift;
        if (s_axis_tuser) begin
            w_phase = PH_MAGIC;
            w_cnt   = '0;
            w_shift = '0;
        end
        w_byte = s_axis_tdata;
        w_word = {w_shift[7:0], w_byte};
        w_size = body_size(w_byte);
        w_n    = {1'b0, w_cnt} + 4'd1;
        w_rem  = (r_rem != '0) ? r_rem - FIELD_W'(1) : '0;
        w_body_done = 1'b0;

        n_phase      = w_phase;
        n_cnt        = w_cnt;
        n_shift      = w_shift;
        n_pool_count = r_pool_count;
        n_index      = r_index;
        n_rem        = r_rem;
        n_offset     = r_offset;
        n_pending    = r_pending;
        n_this       = r_this;
        n_super      = r_super;

        w_push = 1'b0;
        w_res  = '0;

        unique case (w_phase)
            PH_MAGIC: begin
                n_shift = {w_shift[15:0], w_byte};
                n_cnt   = w_cnt + 3'd1;
                if (w_cnt == 3'd3) begin
                    n_cnt   = '0;
                    n_shift = '0;
                    if ({w_shift, w_byte} != MAGIC_WORD) begin
                        n_phase      = PH_DONE;
                        w_push       = 1'b1;
                        w_res.kind   = KIND_BAD_MAGIC;
                    end else begin
                        n_phase = PH_VERSION;
                    end
                end
            end
            PH_VERSION: begin
                n_cnt = w_cnt + 3'd1;
                if (w_cnt == 3'd3) begin
                    n_cnt   = '0;
                    n_phase = PH_COUNT;
                end
            end
            PH_COUNT: begin
                n_shift = {w_shift[15:0], w_byte};
                n_cnt   = w_cnt + 3'd1;
                if (w_cnt == 3'd1) begin
                    n_pool_count = w_word;
                    n_index      = (INDEX_W + 1)'(1);
                    n_offset     = '0;
                    n_cnt        = '0;
                    n_shift      = '0;
                    n_phase      = ((INDEX_W + 1)'(1) < {1'b0, w_word}) ? PH_TAG : PH_ACCESS;
                end
            end
            PH_TAG: begin
                w_push                  = 1'b1;
                w_res.kind              = KIND_ENTRY;
                w_res.data.entry_index  = r_index[INDEX_W-1:0];
                w_res.data.entry_offset = OFFSET_W'(r_offset);
                w_res.data.entry_tag    = w_byte;
                n_pending = (w_byte == TAG_UTF8);
                n_index   = r_index + ((w_byte == TAG_LONG || w_byte == TAG_DOUBLE)
                                       ? (INDEX_W + 1)'(2) : (INDEX_W + 1)'(1));
                n_offset  = r_offset + OFFSET_BITS'(w_size) + OFFSET_BITS'(1);
                n_rem     = FIELD_W'(w_size);
                n_cnt     = '0;
                n_shift   = '0;
                n_phase   = PH_BODY;
            end
            PH_BODY: begin
                n_rem = w_rem;
                if (r_pending) begin
                    n_shift = {w_shift[15:0], w_byte};
                    if (w_rem == '0) begin
                        n_rem       = w_word;
                        n_offset    = r_offset + OFFSET_BITS'(w_word);
                        n_pending   = 1'b0;
                        w_body_done = (w_word == '0);
                    end
                end else begin
                    w_body_done = (w_rem == '0);
                end
                if (w_body_done) begin
                    n_cnt   = '0;
                    n_shift = '0;
                    n_phase = (r_index < {1'b0, r_pool_count}) ? PH_TAG : PH_ACCESS;
                end
            end
            PH_ACCESS: begin
                n_shift = {w_shift[15:0], w_byte};
                if (w_n == 4'd4) begin
                    n_this = w_word;
                end
                if (w_n == 4'd6) begin
                    n_super = w_word;
                end
                if (w_n == 4'd8) begin
                    w_push                     = 1'b1;
                    w_res.kind                 = KIND_SUMMARY;
                    w_res.data.pool_size       = OFFSET_W'(r_offset);
                    w_res.data.self_index      = r_this;
                    w_res.data.parent_index    = r_super;
                    w_res.data.interface_count = w_word;
                    n_cnt   = '0;
                    n_shift = '0;
                    n_phase = PH_DONE;
                end else begin
                    n_cnt = w_n[2:0];
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_MAGIC;
            r_cnt        <= '0;
            r_shift      <= '0;
            r_pool_count <= '0;
            r_index      <= (INDEX_W + 1)'(1);
            r_rem        <= '0;
            r_offset     <= '0;
            r_pending    <= 1'b0;
            r_this       <= '0;
            r_super      <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase      <= n_phase;
                r_cnt        <= n_cnt;
                r_shift      <= n_shift;
                r_pool_count <= n_pool_count;
                r_index      <= n_index;
                r_rem        <= n_rem;
                r_offset     <= n_offset;
                r_pending    <= n_pending;
                r_this       <= n_this;
                r_super      <= n_super;
            end
            if (w_pop) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= w_accept && w_push;
                    r_out       <= w_res;
                end
            end else if (w_accept && w_push) begin
                if (!r_out_valid) begin
                    r_out_valid <= 1'b1;
                    r_out       <= w_res;
                end else begin
                    r_skid_valid <= 1'b1;
                    r_skid       <= w_res;
                end
            end
        end
    end

    // skid register only fills behind a waiting output beat
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a beat while output register is empty");

    // summary or bad magic ends the parse of the file
    a_final_record_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_push && w_res.kind != KIND_ENTRY) |=> r_phase == PH_DONE)
        else $error("parser still active after final record");

    // an entry record always moves the parser into the entry body
    a_entry_to_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_push && w_res.kind == KIND_ENTRY) |=> r_phase == PH_BODY)
        else $error("entry record without body phase");

    // inside a body there is always a byte left or a length still to read
    a_body_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BODY |-> (r_rem != '0 || r_pending))
        else $error("body phase with nothing left to read");

endmodule
